### hdl/vrbb_pkg.sv
// Package with the shared types and constants of the visible region bounding box block.
`timescale 1ns / 1ps

package vrbb_pkg;

  localparam int DEFAULT_MAX_DIMENSION = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int DIM_CFG_W   = 13;
  localparam int LEVEL_W     = 8;

  localparam int OUT_POS_W  = 12;
  localparam int OUT_SIZE_W = 13;

  localparam int RESET_IMAGE_WIDTH     = 640;
  localparam int RESET_IMAGE_HEIGHT    = 480;
  localparam int RESET_ALPHA_THRESHOLD = 16;
  localparam int RESET_LEVEL_THRESHOLD = 14;
  localparam int RESET_MARGIN          = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_ALPHA_THRESHOLD = 3'd2,
    CFG_LEVEL_THRESHOLD = 3'd3,
    CFG_MARGIN          = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic                  found;
    logic [OUT_POS_W-1:0]  box_left;
    logic [OUT_POS_W-1:0]  box_top;
    logic [OUT_SIZE_W-1:0] box_width;
    logic [OUT_SIZE_W-1:0] box_height;
  } box_result_t;

endpackage

### hdl/vrbb_finish.sv
// Pads the tracked box by the margin, clamps it to the image and forms the result word.
`timescale 1ns / 1ps

module vrbb_finish
  import vrbb_pkg::*;
#(
  parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
  input  logic                                  any_visible,
  input  logic [$clog2(MAX_DIMENSION)-1:0]      least_column,
  input  logic [$clog2(MAX_DIMENSION)-1:0]      greatest_column,
  input  logic [$clog2(MAX_DIMENSION)-1:0]      least_row,
  input  logic [$clog2(MAX_DIMENSION)-1:0]      greatest_row,
  input  logic [$clog2(MAX_DIMENSION):0]        width_eff,
  input  logic [$clog2(MAX_DIMENSION):0]        height_eff,
  input  logic [LEVEL_W-1:0]                    margin,
  output box_result_t                           result
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int DW = CW + 1;
  // Wide enough for a coordinate plus the margin without overflow.
  localparam int PW = ((CW > LEVEL_W) ? CW : LEVEL_W) + 1;

  logic [PW-1:0] margin_ext;
  logic [PW-1:0] right_sum;
  logic [PW-1:0] bottom_sum;
  logic [CW-1:0] left;
  logic [CW-1:0] top;
  logic [CW-1:0] right;
  logic [CW-1:0] bottom;
  logic [DW-1:0] box_w;
  logic [DW-1:0] box_h;

  assign margin_ext = PW'(margin);
  assign right_sum  = PW'(greatest_column) + margin_ext;
  assign bottom_sum = PW'(greatest_row) + margin_ext;

  always_comb begin
    left   = (PW'(least_column) > margin_ext) ? CW'(PW'(least_column) - margin_ext) : '0;
    top    = (PW'(least_row) > margin_ext) ? CW'(PW'(least_row) - margin_ext) : '0;
    right  = (right_sum < PW'(width_eff)) ? CW'(right_sum) : CW'(width_eff - DW'(1));
    bottom = (bottom_sum < PW'(height_eff)) ? CW'(bottom_sum) : CW'(height_eff - DW'(1));
    box_w  = DW'(right) - DW'(left) + DW'(1);
    box_h  = DW'(bottom) - DW'(top) + DW'(1);

    if (any_visible) begin
      result.found      = 1'b1;
      result.box_left   = OUT_POS_W'(left);
      result.box_top    = OUT_POS_W'(top);
      result.box_width  = OUT_SIZE_W'(box_w);
      result.box_height = OUT_SIZE_W'(box_h);
    end else begin
      result.found      = 1'b0;
      result.box_left   = '0;
      result.box_top    = '0;
      result.box_width  = OUT_SIZE_W'(width_eff);
      result.box_height = OUT_SIZE_W'(height_eff);
    end
  end

endmodule

### hdl/visible_region_bounding_box_top.sv
// Top level of the visible region bounding box block.
//
//   Port group | Direction | Word          | Handshake
//   in_        | input     | pixel_t       | in_valid / in_ready
//   out_       | output    | box_result_t  | out_valid / out_ready
//   cfg_       | input     | 13-bit data   | cfg_we, no wait
//
// One pixel is accepted per clock while the input is not stalled. Each pixel
// passes an input register and then updates the box trackers; the last pixel
// of an image loads the result register at that same edge, so its result
// word is valid once that pixel has passed the input and result registers.
// A held result stalls the input only when the next image's last pixel
// needs the result register. rst_n is synchronous and restores the register
// reset values; writing the width or height restarts the current image.
`timescale 1ns / 1ps

module visible_region_bounding_box_top
  import vrbb_pkg::*;
#(
  parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  pixel_t                 in_data,

  output logic                   out_valid,
  input  logic                   out_ready,
  output box_result_t            out_data,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int DW = CW + 1;
  localparam int EW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
  localparam int RST_W = (RESET_IMAGE_WIDTH > MAX_DIMENSION) ?
                         MAX_DIMENSION : RESET_IMAGE_WIDTH;
  localparam int RST_H = (RESET_IMAGE_HEIGHT > MAX_DIMENSION) ?
                         MAX_DIMENSION : RESET_IMAGE_HEIGHT;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DW-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) begin
      eff_dim = DW'(1);
    end else if (ve > EW'(MAX_DIMENSION)) begin
      eff_dim = DW'(MAX_DIMENSION);
    end else begin
      eff_dim = DW'(ve);
    end
  endfunction

  // Configuration
  logic [DW-1:0]      width_eff_r;
  logic [DW-1:0]      height_eff_r;
  logic [LEVEL_W-1:0] alpha_thr_r;
  logic [LEVEL_W-1:0] level_thr_r;
  logic [LEVEL_W-1:0] margin_r;
  logic               restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_eff_r  <= DW'(RST_W);
      height_eff_r <= DW'(RST_H);
      alpha_thr_r  <= LEVEL_W'(RESET_ALPHA_THRESHOLD);
      level_thr_r  <= LEVEL_W'(RESET_LEVEL_THRESHOLD);
      margin_r     <= LEVEL_W'(RESET_MARGIN);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     width_eff_r  <= eff_dim(cfg_data);
        CFG_IMAGE_HEIGHT:    height_eff_r <= eff_dim(cfg_data);
        CFG_ALPHA_THRESHOLD: alpha_thr_r  <= cfg_data[LEVEL_W-1:0];
        CFG_LEVEL_THRESHOLD: level_thr_r  <= cfg_data[LEVEL_W-1:0];
        CFG_MARGIN:          margin_r     <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                              (cfg_index == CFG_IMAGE_HEIGHT));

  // Input register
  pixel_t pix_r;
  logic   pix_valid_r;
  logic   pix_last;
  logic   advance;
  logic   out_free;

  logic [CW-1:0] col_r, row_r;
  logic [CW-1:0] lc_r, gc_r, lr_r, gr_r;
  logic          any_r;
  logic [CW-1:0] col_nxt, row_nxt;
  logic [CW-1:0] lc_nxt, gc_nxt, lr_nxt, gr_nxt;
  logic          any_nxt;
  logic [CW-1:0] width_m1;
  logic [CW-1:0] height_m1;
  logic [LEVEL_W-1:0] rg_max;
  logic [LEVEL_W-1:0] rgb_max;
  logic          visible;
  box_result_t   result;

  logic          out_valid_r;
  box_result_t   out_data_r;

  assign width_m1  = CW'(width_eff_r - DW'(1));
  assign height_m1 = CW'(height_eff_r - DW'(1));
  assign pix_last  = (col_r == width_m1) && (row_r == height_m1);
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = pix_valid_r && (!pix_last || out_free);
  assign in_ready  = !pix_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= in_data;
    end
  end

  // Tracker update for the word in the input register
  assign rg_max  = (pix_r.green > pix_r.red) ? pix_r.green : pix_r.red;
  assign rgb_max = (pix_r.blue > rg_max) ? pix_r.blue : rg_max;
  assign visible = (pix_r.alpha > alpha_thr_r) && (rgb_max > level_thr_r);

  always_comb begin
    lc_nxt  = lc_r;
    gc_nxt  = gc_r;
    lr_nxt  = lr_r;
    gr_nxt  = gr_r;
    any_nxt = any_r;
    if (visible) begin
      any_nxt = 1'b1;
      if (!any_r) begin
        lc_nxt = col_r;
        gc_nxt = col_r;
        lr_nxt = row_r;
        gr_nxt = row_r;
      end else begin
        if (col_r < lc_r) lc_nxt = col_r;
        if (col_r > gc_r) gc_nxt = col_r;
        if (row_r < lr_r) lr_nxt = row_r;
        if (row_r > gr_r) gr_nxt = row_r;
      end
    end
    if (col_r == width_m1) begin
      col_nxt = '0;
      row_nxt = (row_r == height_m1) ? '0 : row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  vrbb_finish #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_finish (
    .any_visible     (any_nxt),
    .least_column    (lc_nxt),
    .greatest_column (gc_nxt),
    .least_row       (lr_nxt),
    .greatest_row    (gr_nxt),
    .width_eff       (width_eff_r),
    .height_eff      (height_eff_r),
    .margin          (margin_r),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
      lc_r  <= '0;
      gc_r  <= '0;
      lr_r  <= '0;
      gr_r  <= '0;
      any_r <= 1'b0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (pix_last) begin
        lc_r  <= '0;
        gc_r  <= '0;
        lr_r  <= '0;
        gr_r  <= '0;
        any_r <= 1'b0;
      end else begin
        lc_r  <= lc_nxt;
        gc_r  <= gc_nxt;
        lr_r  <= lr_nxt;
        gr_r  <= gr_nxt;
        any_r <= any_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && pix_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pix_last) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
